### design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int FRAC_BITS_DEFAULT = 15;

   // hue is unsigned Q9.6 degrees
   localparam int HUE_W   = 15;
   localparam int CHAN_W  = 16;
   localparam int REM_W   = 12;
   localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;   // 60 degrees
   localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;  // 360 degrees

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

endpackage

### design/hsv2rgb_stream_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_stream_if
// Valid/ready stream channel carrying one payload struct per beat.
// ----------------------------------------------------------------------------
interface hsv2rgb_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### design/hsv2rgb_pipe.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pipe
// Four-stage HSV to RGB datapath with a common advance enable.
// ----------------------------------------------------------------------------
module hsv2rgb_pipe
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  hsv_type in_data,
   output logic    out_valid,
   output rgb_type out_data
);

   localparam int F     = FRAC_BITS;
   localparam int ONE_W = F + 1;
   localparam int SW    = (F + 1 < CHAN_W) ? F + 1 : CHAN_W;   // clamped s, v
   localparam int CW    = (F + 1 > CHAN_W) ? F + 1 : CHAN_W;   // clamp compare
   localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << F;
   // ff = (rem << F) / 3840 = (rem << (F-8)) / 15, by reciprocal
   localparam int YW    = REM_W + F - 8;
   localparam int K     = YW + 4;
   localparam int MW    = K - 3;
   localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'd14) / 64'd15);
   localparam int RPW   = YW + MW;
   localparam int PW    = SW + ONE_W;

   // stage 1: clamp, wrap, sector split
   logic             s1_valid_ff;
   logic [SW-1:0]    s1_sat_ff, s1_sat_in;
   logic [SW-1:0]    s1_val_ff, s1_val_in;
   logic [REM_W-1:0] s1_rem_ff, s1_rem_in;
   sector_type       s1_sec_ff, s1_sec_in;
   logic             s1_gray_ff, s1_gray_in;

   logic [CW-1:0]    sat_wide, val_wide;
   logic [HUE_W-1:0] hue_wrap, hue_base, rem_wide;

   always_comb begin
      sat_wide = (CW'(in_data.saturation) > CW'(ONE)) ? CW'(ONE) : CW'(in_data.saturation);
      val_wide = (CW'(in_data.brightness) > CW'(ONE)) ? CW'(ONE) : CW'(in_data.brightness);
      s1_sat_in  = sat_wide[SW-1:0];
      s1_val_in  = val_wide[SW-1:0];
      s1_gray_in = (sat_wide == '0);
      hue_wrap   = (in_data.hue >= HUE_FULL) ? '0 : in_data.hue;
      if (hue_wrap < HUE_SECTOR) begin
         s1_sec_in = SEC_RED;
         hue_base  = '0;
      end else if (hue_wrap < HUE_W'(2 * HUE_SECTOR)) begin
         s1_sec_in = SEC_YELLOW;
         hue_base  = HUE_SECTOR;
      end else if (hue_wrap < HUE_W'(3 * HUE_SECTOR)) begin
         s1_sec_in = SEC_GREEN;
         hue_base  = HUE_W'(2 * HUE_SECTOR);
      end else if (hue_wrap < HUE_W'(4 * HUE_SECTOR)) begin
         s1_sec_in = SEC_CYAN;
         hue_base  = HUE_W'(3 * HUE_SECTOR);
      end else if (hue_wrap < HUE_W'(5 * HUE_SECTOR)) begin
         s1_sec_in = SEC_BLUE;
         hue_base  = HUE_W'(4 * HUE_SECTOR);
      end else begin
         s1_sec_in = SEC_MAGENTA;
         hue_base  = HUE_W'(5 * HUE_SECTOR);
      end
      rem_wide  = hue_wrap - hue_base;
      s1_rem_in = rem_wide[REM_W-1:0];
   end

   // stage 2: hue fraction ff
   logic             s2_valid_ff;
   logic [SW-1:0]    s2_sat_ff, s2_val_ff;
   logic [F-1:0]     s2_ff_ff, s2_ff_in;
   sector_type       s2_sec_ff;
   logic             s2_gray_ff;

   logic [RPW-1:0]   recip_prod;

   always_comb begin
      recip_prod = RPW'(YW'(s1_rem_ff) << (F - 8)) * RPW'(RECIP);
      s2_ff_in   = recip_prod[K +: F];
   end

   // stage 3: p, and the q / t multipliers' right-hand terms
   logic             s3_valid_ff;
   logic [SW-1:0]    s3_val_ff;
   logic [SW-1:0]    s3_p_ff, s3_p_in;
   logic [ONE_W-1:0] s3_qterm_ff, s3_qterm_in;
   logic [ONE_W-1:0] s3_tterm_ff, s3_tterm_in;
   sector_type       s3_sec_ff;
   logic             s3_gray_ff;

   logic [ONE_W-1:0] one_m_ff, one_m_s;
   logic [PW-1:0]    sf_prod, sc_prod, p_prod;

   always_comb begin
      one_m_ff    = ONE - ONE_W'(s2_ff_ff);
      one_m_s     = ONE - ONE_W'(s2_sat_ff);
      sf_prod     = PW'(s2_sat_ff) * PW'(s2_ff_ff);
      sc_prod     = PW'(s2_sat_ff) * PW'(one_m_ff);
      p_prod      = PW'(s2_val_ff) * PW'(one_m_s);
      // each product shifted down stays at or below its SW-bit factor
      s3_qterm_in = ONE - ONE_W'(sf_prod[F +: SW]);
      s3_tterm_in = ONE - ONE_W'(sc_prod[F +: SW]);
      s3_p_in     = p_prod[F +: SW];
   end

   // stage 4: q and t
   logic             s4_valid_ff;
   logic [SW-1:0]    s4_val_ff, s4_p_ff;
   logic [SW-1:0]    s4_q_ff, s4_q_in;
   logic [SW-1:0]    s4_t_ff, s4_t_in;
   sector_type       s4_sec_ff;
   logic             s4_gray_ff;

   logic [PW-1:0]    q_prod, t_prod;

   always_comb begin
      q_prod  = PW'(s3_val_ff) * PW'(s3_qterm_ff);
      t_prod  = PW'(s3_val_ff) * PW'(s3_tterm_ff);
      s4_q_in = q_prod[F +: SW];
      s4_t_in = t_prod[F +: SW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sat_ff   <= s1_sat_in;
         s1_val_ff   <= s1_val_in;
         s1_rem_ff   <= s1_rem_in;
         s1_sec_ff   <= s1_sec_in;
         s1_gray_ff  <= s1_gray_in;

         s2_sat_ff   <= s1_sat_ff;
         s2_val_ff   <= s1_val_ff;
         s2_ff_ff    <= s2_ff_in;
         s2_sec_ff   <= s1_sec_ff;
         s2_gray_ff  <= s1_gray_ff;

         s3_val_ff   <= s2_val_ff;
         s3_p_ff     <= s3_p_in;
         s3_qterm_ff <= s3_qterm_in;
         s3_tterm_ff <= s3_tterm_in;
         s3_sec_ff   <= s2_sec_ff;
         s3_gray_ff  <= s2_gray_ff;

         s4_val_ff   <= s3_val_ff;
         s4_p_ff     <= s3_p_ff;
         s4_q_ff     <= s4_q_in;
         s4_t_ff     <= s4_t_in;
         s4_sec_ff   <= s3_sec_ff;
         s4_gray_ff  <= s3_gray_ff;
      end
   end

   // sector routing
   logic [CHAN_W-1:0] v16, p16, q16, t16;

   always_comb begin
      v16 = CHAN_W'(s4_val_ff);
      p16 = CHAN_W'(s4_p_ff);
      q16 = CHAN_W'(s4_q_ff);
      t16 = CHAN_W'(s4_t_ff);
      if (s4_gray_ff) begin
         out_data = '{red: v16, green: v16, blue: v16};
      end else begin
         unique case (s4_sec_ff)
            SEC_RED:    out_data = '{red: v16, green: t16, blue: p16};
            SEC_YELLOW: out_data = '{red: q16, green: v16, blue: p16};
            SEC_GREEN:  out_data = '{red: p16, green: v16, blue: t16};
            SEC_CYAN:   out_data = '{red: p16, green: q16, blue: v16};
            SEC_BLUE:   out_data = '{red: t16, green: p16, blue: v16};
            default:    out_data = '{red: v16, green: p16, blue: q16};
         endcase
      end
   end

   assign out_valid = s4_valid_ff;

endmodule

### design/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV to RGB color conversion, one pixel per clock while rsp_bus accepts, with an output skid.
//
//   channel   dir  modport  payload
//   req_bus   in   sink     hue Q9.6, saturation Q1.15, brightness Q1.15
//   rsp_bus   out  source   red, green, blue Q1.15
//
// One pixel per clock sustained while rsp_bus accepts; a pixel reaches rsp_bus
// from its req_bus beat through 4 datapath stages plus the output register.
// Depth is set by the reciprocal multiply for the hue fraction and the two
// chained multiplier stages that form q and t.
// Synchronous reset clears all valid bits. A stalled output parks one
// pixel in the skid register; req_bus.ready is a register, not a path from
// rsp_bus.ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   hsv2rgb_stream_if.sink    req_bus,
   hsv2rgb_stream_if.source  rsp_bus
);

   logic    advance;
   logic    pipe_valid;
   rgb_type pipe_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rgb_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rgb_type skid_data_ff, skid_data_in;
   logic    rsp_fire, push;

   // the whole pipeline holds while the skid register is occupied
   assign advance       = !skid_valid_ff;
   assign req_bus.ready = advance;

   hsv2rgb_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_bus.valid),
      .in_data   (req_bus.data),
      .out_valid (pipe_valid),
      .out_data  (pipe_data)
   );

   always_comb begin
      rsp_fire      = rsp_valid_ff && rsp_bus.ready;
      push          = advance && pipe_valid;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = pipe_data;
         end else begin
            rsp_valid_in  = 1'b0;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

endmodule
